FILE: hdl/smdm_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo multitap delay mixer package
// Shared widths, register indexes and control types of the delay mixer.
// ----------------------------------------------------------------------------
package smdm_pkg;

    // The ring depth must be a power of two so that pointer arithmetic wraps.
    localparam int DELAY_DEPTH = 65536;
    localparam int NUM_TAPS    = 4;
    localparam int TAP_REGS    = 4;

    localparam int ADDR_W    = $clog2(DELAY_DEPTH);
    localparam int SMP_W     = 16;
    localparam int WORD_W    = 2 * SMP_W;
    localparam int DLY_W     = 16;
    localparam int GAIN_W    = 16;
    localparam int MIX_W     = 16;
    localparam int TAP_W     = DLY_W + 2 * GAIN_W;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = TAP_W;
    localparam int TAP_IDX_W = $clog2(TAP_REGS);
    localparam int STEP_W    = $clog2(NUM_TAPS + 2);

    localparam int OPD_W  = SMP_W + 1;
    localparam int PROD_W = 2 * OPD_W;
    localparam int ACC_W  = PROD_W + $clog2(NUM_TAPS) + 1;
    localparam int FRAC_W = 15;

    localparam logic [OPD_W-1:0] UNITY_Q15 = OPD_W'(32768);

    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ZERO  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_ONE   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_TWO   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_TAP_THREE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_WET_MIX   = CFG_IDX_W'(4);

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD
    } t_acc_op;

    typedef struct packed {
        logic    mul_en;
        t_acc_op acc_op;
    } t_mac_ctrl;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [WORD_W-1:0] wr_data;
        logic              rd_en;
        logic [ADDR_W-1:0] rd_addr;
    } t_ring_req;

endpackage
`default_nettype wire

FILE: hdl/smdm_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo multitap delay mixer channels
// Sample input, sample output and register write channels.
// ----------------------------------------------------------------------------
interface smdm_in_if import smdm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_in;
    logic signed [SMP_W-1:0] right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink (input valid, input left_in, input right_in, output ready);
endinterface

interface smdm_out_if import smdm_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [SMP_W-1:0] left_out;
    logic signed [SMP_W-1:0] right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink (input valid, input left_out, input right_out, output ready);
endinterface

interface smdm_cfg_if import smdm_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

FILE: hdl/stereo_multitap_delay_mixer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Stereo multitap delay mixer
// Writes each stereo pair into a ring memory, reads one tap per cycle,
// weights and sums the taps into a wet signal and blends it with the dry pair.
//
//   Channel  Direction  Payload                  Request moves
//   i_in     sink       left_in, right_in        one stereo input pair
//   o_out    source     left_out, right_out      one blended output pair
//   i_cfg    sink       index, data              one register write
//
// For each item, the single ring read port serves one tap per cycle into the
// two lane multipliers, followed by wet rounding, the blend multiply and the
// output load.
// Reset is ready at once; a fill count replaces a clearing pass of the ring.
// A finished result waits in the output register while a new pair is taken;
// the sequencer holds its last step while that register is still occupied.
// ----------------------------------------------------------------------------
module stereo_multitap_delay_mixer_core import smdm_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    smdm_in_if.sink   i_in,
    smdm_out_if.source o_out,
    smdm_cfg_if.sink  i_cfg
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_TAPS,
        S_WET,
        S_BMUL,
        S_BACC,
        S_DONE
    } t_state;

    t_state                  r_state;
    logic [STEP_W-1:0]       r_step;
    logic [ADDR_W-1:0]       r_wp;
    logic [TAP_W-1:0]        r_taps [TAP_REGS];
    logic [MIX_W-1:0]        r_wet_mix;
    logic signed [SMP_W-1:0] r_dry_l;
    logic signed [SMP_W-1:0] r_dry_r;
    logic [GAIN_W-1:0]       r_gain_l;
    logic [GAIN_W-1:0]       r_gain_r;
    logic signed [SMP_W-1:0] r_wet_l;
    logic signed [SMP_W-1:0] r_wet_r;
    logic                    r_out_valid;
    logic signed [SMP_W-1:0] r_out_l;
    logic signed [SMP_W-1:0] r_out_r;

    t_ring_req               w_ring;
    logic [WORD_W-1:0]       w_rdata;
    logic [TAP_W-1:0]        w_tap;
    logic [ADDR_W-1:0]       w_dly;
    logic                    w_accept;
    logic                    w_out_free;
    logic [OPD_W-1:0]        w_mix;
    t_mac_ctrl               w_mac;
    logic signed [OPD_W-1:0] w_a_l;
    logic signed [OPD_W-1:0] w_a_r;
    logic signed [OPD_W-1:0] w_b_l;
    logic signed [OPD_W-1:0] w_b_r;
    logic signed [ACC_W-1:0] w_base_l;
    logic signed [ACC_W-1:0] w_base_r;
    logic signed [SMP_W-1:0] w_sat_l;
    logic signed [SMP_W-1:0] w_sat_r;

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_tap      = r_taps[r_step[TAP_IDX_W-1:0]];
    assign w_dly      = ADDR_W'(w_tap[DLY_W-1:0]);
    assign w_mix      = (OPD_W'(r_wet_mix) > UNITY_Q15) ? UNITY_Q15 : OPD_W'(r_wet_mix);

    assign i_in.ready      = (r_state == S_IDLE);
    assign i_cfg.ready     = 1'b1;
    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

    always_comb begin
        w_ring.wr_en   = w_accept;
        w_ring.wr_addr = r_wp;
        w_ring.wr_data = {i_in.right_in, i_in.left_in};
        w_ring.rd_en   = (r_state == S_TAPS) && (r_step < STEP_W'(NUM_TAPS));
        w_ring.rd_addr = r_wp - w_dly;
    end

    always_comb begin
        w_mac.mul_en = 1'b0;
        w_mac.acc_op = ACC_HOLD;
        w_a_l        = $signed({w_rdata[SMP_W-1], w_rdata[SMP_W-1:0]});
        w_a_r        = $signed({w_rdata[WORD_W-1], w_rdata[WORD_W-1:SMP_W]});
        w_b_l        = $signed({1'b0, r_gain_l});
        w_b_r        = $signed({1'b0, r_gain_r});
        w_base_l     = '0;
        w_base_r     = '0;
        unique case (r_state)
            S_TAPS: begin
                w_mac.mul_en = (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(NUM_TAPS));
                if (r_step == STEP_W'(2)) begin
                    w_mac.acc_op = ACC_LOAD;
                end else if (r_step > STEP_W'(2)) begin
                    w_mac.acc_op = ACC_ADD;
                end
            end
            S_BMUL: begin
                w_mac.mul_en = 1'b1;
                w_a_l        = OPD_W'(r_wet_l) - OPD_W'(r_dry_l);
                w_a_r        = OPD_W'(r_wet_r) - OPD_W'(r_dry_r);
                w_b_l        = $signed(w_mix);
                w_b_r        = $signed(w_mix);
            end
            S_BACC: begin
                w_mac.acc_op = ACC_LOAD;
                w_base_l     = ACC_W'(r_dry_l) <<< FRAC_W;
                w_base_r     = ACC_W'(r_dry_r) <<< FRAC_W;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_wp        <= '0;
            r_wet_mix   <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < TAP_REGS; k++) begin
                r_taps[k] <= '0;
            end
        end else begin
            if (i_cfg.valid) begin
                unique case (i_cfg.index) inside
                    CFG_TAP_ZERO, CFG_TAP_ONE, CFG_TAP_TWO, CFG_TAP_THREE: begin
                        r_taps[i_cfg.index[TAP_IDX_W-1:0]] <= i_cfg.data;
                    end
                    CFG_WET_MIX: begin
                        r_wet_mix <= i_cfg.data[MIX_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end

            if (r_out_valid && o_out.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_dry_l <= i_in.left_in;
                        r_dry_r <= i_in.right_in;
                        r_step  <= '0;
                        r_state <= S_TAPS;
                    end
                end
                S_TAPS: begin
                    if (w_ring.rd_en) begin
                        r_gain_l <= w_tap[DLY_W+GAIN_W-1:DLY_W];
                        r_gain_r <= w_tap[TAP_W-1:DLY_W+GAIN_W];
                    end
                    if (r_step == STEP_W'(NUM_TAPS + 1)) begin
                        r_state <= S_WET;
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_WET: begin
                    r_wet_l <= w_sat_l;
                    r_wet_r <= w_sat_r;
                    r_state <= S_BMUL;
                end
                S_BMUL: begin
                    r_state <= S_BACC;
                end
                S_BACC: begin
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (w_out_free) begin
                        r_out_l     <= w_sat_l;
                        r_out_r     <= w_sat_r;
                        r_out_valid <= 1'b1;
                        r_wp        <= r_wp + 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    smdm_ring u_ring (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_ring),
        .o_rdata (w_rdata)
    );

    smdm_mac u_mac_l (
        .i_clk  (i_clk),
        .i_ctrl (w_mac),
        .i_a    (w_a_l),
        .i_b    (w_b_l),
        .i_base (w_base_l),
        .o_sat  (w_sat_l)
    );

    smdm_mac u_mac_r (
        .i_clk  (i_clk),
        .i_ctrl (w_mac),
        .i_a    (w_a_r),
        .i_b    (w_b_r),
        .i_base (w_base_r),
        .o_sat  (w_sat_r)
    );

endmodule
`default_nettype wire

FILE: hdl/smdm_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Delay ring memory
// One write and one registered read per cycle. A fill count makes entries
// that were never written since reset read as zero.
// ----------------------------------------------------------------------------
module smdm_ring import smdm_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire t_ring_req         i_req,
    output logic      [WORD_W-1:0] o_rdata
);

    logic [WORD_W-1:0] r_mem [DELAY_DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              r_hit;
    logic [ADDR_W:0]   r_fill;
    logic              n_hit;

    always_comb begin
        n_hit = r_fill[ADDR_W] || (i_req.rd_addr < r_fill[ADDR_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rdata <= r_mem[i_req.rd_addr];
            r_hit   <= n_hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_req.wr_en && !r_fill[ADDR_W]) begin
            r_fill <= r_fill + 1'b1;
        end
    end

    assign o_rdata = r_hit ? r_rdata : '0;

endmodule
`default_nettype wire

FILE: hdl/smdm_mac.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Multiply-accumulate lane
// One registered signed multiply feeding an accumulator, with Q15 rounding
// and 16-bit saturation of the accumulated value.
// ----------------------------------------------------------------------------
module smdm_mac import smdm_pkg::*; (
    input  wire logic                     i_clk,
    input  wire t_mac_ctrl                i_ctrl,
    input  wire logic signed [OPD_W-1:0]  i_a,
    input  wire logic signed [OPD_W-1:0]  i_b,
    input  wire logic signed [ACC_W-1:0]  i_base,
    output logic      signed [SMP_W-1:0]  o_sat
);

    localparam int Q_W = ACC_W - FRAC_W;
    localparam logic signed [Q_W-1:0] SAT_MAX = Q_W'(32767);
    localparam logic signed [Q_W-1:0] SAT_MIN = -Q_W'(32768);

    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic signed [ACC_W-1:0]  w_rnd;
    logic signed [Q_W-1:0]    w_q;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_en) begin
            r_prod <= i_a * i_b;
        end
        case (i_ctrl.acc_op)
            ACC_LOAD: r_acc <= i_base + ACC_W'(r_prod);
            ACC_ADD:  r_acc <= r_acc + ACC_W'(r_prod);
            default:  r_acc <= r_acc;
        endcase
    end

    always_comb begin
        w_rnd = r_acc + ACC_W'(16384);
        w_q   = w_rnd[ACC_W-1:FRAC_W];
        if (w_q > SAT_MAX) begin
            o_sat = SAT_MAX[SMP_W-1:0];
        end else if (w_q < SAT_MIN) begin
            o_sat = SAT_MIN[SMP_W-1:0];
        end else begin
            o_sat = w_q[SMP_W-1:0];
        end
    end

endmodule
`default_nettype wire
